### rtl/core/tbop_pkg.sv
// Package for the timer bank: sizes, request and result codes, payload types,
// state machine states and the flag-bank command/status structs.
// No dependencies.
package tbop_pkg;

    localparam int TIMERS    = 16;
    localparam int TIME_BITS = 16;

    localparam int IDX_W   = $clog2(TIMERS);
    localparam int CNT_W   = $clog2(TIMERS + 1);
    localparam int TYPE_W  = 3;
    localparam int DUR_W   = 16;
    localparam int SLOT_W  = 4;
    localparam int NEXT_W  = 16;
    localparam int ENTRY_W = 2 * TIME_BITS;

    localparam logic [TYPE_W-1:0] REQ_ADD_ONE = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_ADD_PER = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_DESTROY = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_QUERY   = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_TICK    = 3'd4;

    localparam logic [TYPE_W-1:0] KIND_ADD     = 3'd0;
    localparam logic [TYPE_W-1:0] KIND_DESTROY = 3'd1;
    localparam logic [TYPE_W-1:0] KIND_FIRE    = 3'd2;
    localparam logic [TYPE_W-1:0] KIND_NEXT    = 3'd3;
    localparam logic [TYPE_W-1:0] KIND_TICK    = 3'd4;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [DUR_W-1:0]  duration_ms;
        logic [SLOT_W-1:0] handle;
    } t_req;

    typedef struct packed {
        logic [TYPE_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic              ok;
        logic [NEXT_W-1:0] next_ms;
        logic              loop_expired;
        logic              last;
    } t_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_QRUN,
        S_TRUN
    } t_state;

    typedef struct packed {
        logic             set;
        logic             clr;
        logic             periodic;
        logic [IDX_W-1:0] idx;
    } t_flag_cmd;

    typedef struct packed {
        logic [TIMERS-1:0] active;
        logic [TIMERS-1:0] periodic;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
    } t_flag_stat;

    function automatic logic [TIME_BITS-1:0] clamp_time(input logic [DUR_W-1:0] d);
        logic [DUR_W-1:0] hi;
        hi = d >> TIME_BITS;
        if (hi != '0) return '1;
        return TIME_BITS'(d);
    endfunction

    function automatic logic [NEXT_W-1:0] sat_next(input logic [TIME_BITS-1:0] t);
        logic [TIME_BITS-1:0] hi;
        hi = t >> NEXT_W;
        if (hi != '0) return '1;
        return NEXT_W'(t);
    endfunction

endpackage

### rtl/core/tbop_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds while read enable is low. No dependencies.
module tbop_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/tbop_slot_flags.sv
// Per-slot active and periodic flags in flip-flops, plus the lowest-free-slot
// encoder used by add requests. Depends on tbop_pkg.
module tbop_slot_flags
    import tbop_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_flag_cmd  i_cmd,
    output t_flag_stat o_stat
);

    logic [TIMERS-1:0] r_active;
    logic [TIMERS-1:0] r_periodic;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= '0;
            r_periodic <= '0;
        end else if (i_cmd.set) begin
            r_active[i_cmd.idx]   <= 1'b1;
            r_periodic[i_cmd.idx] <= i_cmd.periodic;
        end else if (i_cmd.clr) begin
            r_active[i_cmd.idx]   <= 1'b0;
            r_periodic[i_cmd.idx] <= 1'b0;
        end
    end

    // lowest index wins: walk from the top so the last hit is the lowest
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TIMERS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign o_stat.active     = r_active;
    assign o_stat.periodic   = r_periodic;
    assign o_stat.free_found = free_found;
    assign o_stat.free_idx   = free_idx;

endmodule

### rtl/core/timer_bank_oneshot_periodic_unit.sv
// Timer bank top level: request sequencer, slot scan, deadline counter and
// result register. Depends on tbop_pkg, tbop_ram and tbop_slot_flags.
//
// A bank of TIMERS one-shot or periodic millisecond timers. Add and destroy
// requests each give one result. Query and tick requests scan every slot
// through the single read port of the count memory, one slot per cycle,
// except that a tick scan holds while the result side stalls a fire result.
// A tick gives one fire result per expiring slot in ascending slot order and
// then a tick-done result; every other request gives one result, marked
// last. Request codes 5 to 7 are dropped without a result. Input transfers
// are taken only while the sequencer is idle and the result register can
// take a new result. The count memory needs no clearing pass: only slots
// written by an add are used.
module timer_bank_oneshot_periodic_unit
    import tbop_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_item,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_res o_out_item
);

    t_state r_state, n_state;
    logic [CNT_W-1:0]     r_rd_cnt, n_rd_cnt;
    logic                 r_up_vld, n_up_vld;
    logic [IDX_W-1:0]     r_up_idx, n_up_idx;
    logic                 r_any, n_any;
    logic [TIME_BITS-1:0] r_least, n_least;
    logic                 r_loop_armed, n_loop_armed;
    logic [TIME_BITS-1:0] r_loop_rem, n_loop_rem;
    logic                 r_out_vld;
    t_res                 r_out, n_out;
    logic                 out_load;

    t_flag_cmd  flag_cmd;
    t_flag_stat flag_stat;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [TIME_BITS-1:0] rd_period;
    logic [TIME_BITS-1:0] rd_rem;
    logic [TIME_BITS-1:0] dur_c;
    logic [TIME_BITS-1:0] loop_dec;
    logic out_free, in_acc, scan_rd, up_act, up_fire, hold, h_ok;

    tbop_slot_flags u_flags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (flag_cmd),
        .o_stat  (flag_stat)
    );

    // entry layout: period in the upper half, remaining count in the lower
    tbop_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TIMERS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_period = ram_rdata[ENTRY_W-1:TIME_BITS];
    assign rd_rem    = ram_rdata[TIME_BITS-1:0];
    assign dur_c     = clamp_time(i_in_item.duration_ms);
    assign loop_dec  = (r_loop_armed && r_loop_rem != '0) ? r_loop_rem - 1'b1 : r_loop_rem;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign o_in_stall = !(r_state == S_IDLE && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign scan_rd = r_rd_cnt < CNT_W'(TIMERS);
    assign up_act  = r_up_vld && flag_stat.active[r_up_idx];
    assign up_fire = up_act && (rd_rem <= TIME_BITS'(1));
    assign hold    = up_fire && !out_free;
    assign h_ok    = (32'(i_in_item.handle) < TIMERS)
                     && flag_stat.active[IDX_W'(i_in_item.handle)];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rd_cnt     <= '0;
            r_up_vld     <= 1'b0;
            r_up_idx     <= '0;
            r_any        <= 1'b0;
            r_least      <= '0;
            r_loop_armed <= 1'b0;
            r_loop_rem   <= '0;
        end else begin
            r_state      <= n_state;
            r_rd_cnt     <= n_rd_cnt;
            r_up_vld     <= n_up_vld;
            r_up_idx     <= n_up_idx;
            r_any        <= n_any;
            r_least      <= n_least;
            r_loop_armed <= n_loop_armed;
            r_loop_rem   <= n_loop_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_rd_cnt     = r_rd_cnt;
        n_up_vld     = r_up_vld;
        n_up_idx     = r_up_idx;
        n_any        = r_any;
        n_least      = r_least;
        n_loop_armed = r_loop_armed;
        n_loop_rem   = r_loop_rem;
        n_out        = '0;
        out_load     = 1'b0;
        flag_cmd     = '0;
        ram_we       = 1'b0;
        ram_waddr    = r_up_idx;
        ram_wdata    = {rd_period, rd_rem};
        ram_re       = 1'b0;
        ram_raddr    = r_rd_cnt[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_item.req_type) inside
                        REQ_ADD_ONE, REQ_ADD_PER: begin
                            n_out.kind = KIND_ADD;
                            n_out.last = 1'b1;
                            out_load   = 1'b1;
                            if (i_in_item.duration_ms != '0 && flag_stat.free_found) begin
                                flag_cmd.set      = 1'b1;
                                flag_cmd.idx      = flag_stat.free_idx;
                                flag_cmd.periodic = (i_in_item.req_type == REQ_ADD_PER);
                                ram_we            = 1'b1;
                                ram_waddr         = flag_stat.free_idx;
                                ram_wdata         = {dur_c, dur_c};
                                n_out.ok          = 1'b1;
                                n_out.slot        = SLOT_W'(flag_stat.free_idx);
                            end
                        end
                        REQ_DESTROY: begin
                            n_out.kind = KIND_DESTROY;
                            n_out.slot = i_in_item.handle;
                            n_out.ok   = h_ok;
                            n_out.last = 1'b1;
                            out_load   = 1'b1;
                            if (h_ok) begin
                                flag_cmd.clr = 1'b1;
                                flag_cmd.idx = IDX_W'(i_in_item.handle);
                            end
                        end
                        REQ_QUERY: begin
                            n_loop_armed = (i_in_item.duration_ms != '0);
                            n_loop_rem   = (i_in_item.duration_ms != '0) ? dur_c : '0;
                            n_any        = (i_in_item.duration_ms != '0);
                            n_least      = (i_in_item.duration_ms != '0) ? dur_c : '0;
                            n_rd_cnt     = '0;
                            n_up_vld     = 1'b0;
                            n_state      = S_QRUN;
                        end
                        REQ_TICK: begin
                            n_rd_cnt = '0;
                            n_up_vld = 1'b0;
                            n_state  = S_TRUN;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_QRUN: begin
                if (scan_rd) begin
                    ram_re   = 1'b1;
                    n_rd_cnt = r_rd_cnt + 1'b1;
                    n_up_vld = 1'b1;
                    n_up_idx = r_rd_cnt[IDX_W-1:0];
                end else begin
                    n_up_vld = 1'b0;
                end
                if (up_act && (!r_any || rd_rem < r_least)) begin
                    n_any   = 1'b1;
                    n_least = rd_rem;
                end
                if (!scan_rd && !r_up_vld && out_free) begin
                    n_out.kind    = KIND_NEXT;
                    n_out.ok      = r_any;
                    n_out.next_ms = r_any ? sat_next(r_least) : '0;
                    n_out.last    = 1'b1;
                    out_load      = 1'b1;
                    n_state       = S_IDLE;
                end
            end

            S_TRUN: begin
                // hold both stages while a fire result waits for room
                if (!hold) begin
                    if (scan_rd) begin
                        ram_re   = 1'b1;
                        n_rd_cnt = r_rd_cnt + 1'b1;
                        n_up_vld = 1'b1;
                        n_up_idx = r_rd_cnt[IDX_W-1:0];
                    end else begin
                        n_up_vld = 1'b0;
                    end
                    if (up_act) begin
                        ram_we = 1'b1;
                        if (up_fire) begin
                            n_out.kind = KIND_FIRE;
                            n_out.slot = SLOT_W'(r_up_idx);
                            n_out.ok   = 1'b1;
                            out_load   = 1'b1;
                            if (flag_stat.periodic[r_up_idx]) begin
                                ram_wdata = {rd_period, rd_period};
                            end else begin
                                ram_wdata    = {rd_period, {TIME_BITS{1'b0}}};
                                flag_cmd.clr = 1'b1;
                                flag_cmd.idx = r_up_idx;
                            end
                        end else begin
                            ram_wdata = {rd_period, rd_rem - 1'b1};
                        end
                    end
                end
                if (!scan_rd && !r_up_vld && out_free) begin
                    n_loop_rem         = loop_dec;
                    n_out.kind         = KIND_TICK;
                    n_out.ok           = 1'b1;
                    n_out.loop_expired = r_loop_armed && (loop_dec == '0);
                    n_out.last         = 1'b1;
                    out_load           = 1'b1;
                    n_state            = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

`ifndef NO_ASSERTIONS
    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result loaded while result register is full and stalled");

    a_idle_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_up_vld)
        else $error("scan update stage busy while idle");

    a_disarmed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_loop_armed |-> (r_loop_rem == '0))
        else $error("disarmed deadline holds a nonzero count");
`endif

endmodule
